// File: rtl/tss_pkg.sv
// Shared types, constants and lookup functions for the tactile scan sequencer.
package tss_pkg;

  localparam int SENSORS_PER_PORT = 9;
  localparam int PORT_COUNT       = 4;

  localparam int PORT_W   = 2;
  localparam int CNT_W    = 4;
  localparam int TIME_W   = 32;
  localparam int IDX_W    = 6;
  localparam int DELAY_W  = 16;
  localparam int ADDR_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_BYTES_W  = 64;
  localparam int OUT_BYTES_W = 64;

  localparam logic [DELAY_W-1:0] SETTLE_RESET      = 16'd3000;
  localparam logic [ADDR_W-1:0]  ENABLE_ALL_RESET  = 8'd12;
  localparam logic [ADDR_W-1:0]  DISABLE_ALL_RESET = 8'd13;
  localparam logic [ADDR_W-1:0]  BAROMETER_RESET   = 8'd192;

  localparam logic [15:0] START_CONV_DATA = 16'h1201;
  localparam logic [9:0]  PRESSURE_BASE   = 10'd510;
  localparam logic [7:0]  PRESSURE_KNEE   = 8'd200;
  localparam logic [9:0]  PRESSURE_WRAP   = 10'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE_DELAY = 2'd0,
    REG_ENABLE_ALL   = 2'd1,
    REG_DISABLE_ALL  = 2'd2,
    REG_BAROMETER    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_EN_ALL     = 3'd1,
    PH_START      = 3'd2,
    PH_DIS_ALL    = 3'd3,
    PH_EN_SENSOR  = 3'd4,
    PH_SET_REG    = 3'd5,
    PH_READ       = 3'd6,
    PH_DIS_SENSOR = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    STAT_NONE   = 2'd0,
    STAT_FINGER = 2'd1,
    STAT_SENSOR = 2'd2
  } status_kind_t;

  typedef struct packed {
    logic [DELAY_W-1:0] settle_delay_us;
    logic [ADDR_W-1:0]  enable_all_address;
    logic [ADDR_W-1:0]  disable_all_address;
    logic [ADDR_W-1:0]  barometer_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        read_byte_three;
    logic [7:0]        read_byte_two;
    logic [7:0]        read_byte_zero;
    logic              xfer_ok;
    logic [TIME_W-1:0] now_us;
    logic              start_scan;
    logic [PORT_W-1:0] port;
  } item_t;

  typedef struct packed {
    phase_t            phase;
    logic [CNT_W-1:0]  counter;
    logic [TIME_W-1:0] start_time;
  } port_state_t;

  typedef struct packed {
    logic [9:0]        temperature;
    logic [8:0]        pressure;
    logic              reading_valid;
    logic [IDX_W-1:0]  status_index;
    logic              status_ok;
    logic [1:0]        status_kind;
    logic [15:0]       cmd_data;
    logic [2:0]        cmd_length;
    logic [ADDR_W-1:0] cmd_address;
    logic [1:0]        cmd_kind;
  } result_t;

  function automatic logic [ADDR_W-1:0] sensor_address(input logic [CNT_W-1:0] idx);
    case (idx)
      4'd0:    sensor_address = 8'h00;
      4'd1:    sensor_address = 8'h02;
      4'd2:    sensor_address = 8'h04;
      4'd3:    sensor_address = 8'h06;
      4'd4:    sensor_address = 8'h08;
      4'd5:    sensor_address = 8'h10;
      4'd6:    sensor_address = 8'h12;
      4'd7:    sensor_address = 8'h14;
      default: sensor_address = 8'h16;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] finger_of_port(input logic [PORT_W-1:0] p);
    case (p)
      2'd0:    finger_of_port = 6'd0;
      2'd1:    finger_of_port = 6'd2;
      2'd2:    finger_of_port = 6'd1;
      default: finger_of_port = 6'd3;
    endcase
  endfunction

endpackage

// File: rtl/tss_cfg.sv
// Configuration register file for the scan sequencer.
module tss_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [tss_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0] wr_data,
  output tss_pkg::cfg_t                  cfg
);
  import tss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_delay_us     <= SETTLE_RESET;
      cfg.enable_all_address  <= ENABLE_ALL_RESET;
      cfg.disable_all_address <= DISABLE_ALL_RESET;
      cfg.barometer_address   <= BAROMETER_RESET;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_SETTLE_DELAY: cfg.settle_delay_us     <= wr_data[DELAY_W-1:0];
        REG_ENABLE_ALL:   cfg.enable_all_address  <= wr_data[ADDR_W-1:0];
        REG_DISABLE_ALL:  cfg.disable_all_address <= wr_data[ADDR_W-1:0];
        REG_BAROMETER:    cfg.barometer_address   <= wr_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tss_step.sv
// Per-tick phase logic: next port state and the command/status/reading result.
module tss_step (
  input  tss_pkg::item_t       item,
  input  tss_pkg::port_state_t cur,
  input  tss_pkg::cfg_t        cfg,
  output tss_pkg::port_state_t nxt,
  output logic                 write_state,
  output tss_pkg::result_t     res
);
  import tss_pkg::*;

  logic              in_range;
  logic [CNT_W-1:0]  sidx;
  logic [ADDR_W-1:0] saddr;
  logic [IDX_W-1:0]  finger;
  logic [IDX_W-1:0]  slot;
  logic [TIME_W-1:0] elapsed;
  logic              settled;
  logic              last_sensor;
  logic [9:0]        b0_adj;
  logic [9:0]        press_full;

  assign in_range    = ({1'b0, item.port} < 3'(PORT_COUNT));
  assign write_state = in_range;
  assign sidx        = (cur.counter < CNT_W'(SENSORS_PER_PORT)) ? cur.counter
                                                                : CNT_W'(SENSORS_PER_PORT - 1);
  assign saddr       = sensor_address(sidx);
  assign finger      = finger_of_port(item.port);
  assign slot        = IDX_W'(item.port) * IDX_W'(SENSORS_PER_PORT) + IDX_W'(cur.counter);
  assign elapsed     = item.now_us - cur.start_time;
  assign settled     = (cur.counter != '0) || (elapsed > TIME_W'(cfg.settle_delay_us));
  assign last_sensor = ({1'b0, cur.counter} + 5'd2) > 5'(SENSORS_PER_PORT);
  assign b0_adj      = (item.read_byte_zero < PRESSURE_KNEE)
                       ? ({2'b0, item.read_byte_zero} + PRESSURE_WRAP)
                       : {2'b0, item.read_byte_zero};
  assign press_full  = PRESSURE_BASE - b0_adj;

  // next state
  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_IDLE:      if (item.start_scan) nxt.phase = PH_EN_ALL;
      PH_EN_ALL:    nxt.phase = PH_START;
      PH_START: begin
        nxt.phase      = PH_DIS_ALL;
        nxt.start_time = item.now_us;
      end
      PH_DIS_ALL:   nxt.phase = PH_EN_SENSOR;
      PH_EN_SENSOR: if (settled) nxt.phase = PH_SET_REG;
      PH_SET_REG:   nxt.phase = PH_READ;
      PH_READ:      nxt.phase = PH_DIS_SENSOR;
      PH_DIS_SENSOR: begin
        nxt.counter = cur.counter + 1'b1;
        if (last_sensor) begin
          nxt.phase   = PH_IDLE;
          nxt.counter = '0;
        end else if (item.xfer_ok) begin
          nxt.phase = PH_EN_SENSOR;
        end
      end
      default: nxt = cur;
    endcase
  end

  // result
  always_comb begin
    res = '0;
    if (in_range) begin
      case (cur.phase)
        PH_IDLE: ;
        PH_EN_ALL: begin
          res.cmd_kind     = CMD_WRITE;
          res.cmd_address  = cfg.enable_all_address;
          res.status_kind  = STAT_FINGER;
          res.status_ok    = item.xfer_ok;
          res.status_index = finger;
        end
        PH_START: begin
          res.cmd_kind    = CMD_WRITE;
          res.cmd_address = cfg.barometer_address;
          res.cmd_length  = 3'd2;
          res.cmd_data    = START_CONV_DATA;
        end
        PH_DIS_ALL: begin
          res.cmd_kind     = CMD_READ;
          res.cmd_address  = cfg.disable_all_address >> 1;
          res.cmd_length   = 3'd1;
          res.status_kind  = STAT_FINGER;
          res.status_ok    = item.xfer_ok;
          res.status_index = finger;
        end
        PH_EN_SENSOR: begin
          // hold with an empty beat until the conversion has settled
          if (settled) begin
            res.cmd_kind     = CMD_WRITE;
            res.cmd_address  = saddr;
            res.status_kind  = STAT_FINGER;
            res.status_ok    = item.xfer_ok;
            res.status_index = finger;
          end
        end
        PH_SET_REG: begin
          res.cmd_kind     = CMD_WRITE;
          res.cmd_address  = cfg.barometer_address;
          res.cmd_length   = 3'd1;
          res.status_kind  = STAT_SENSOR;
          res.status_ok    = item.xfer_ok;
          res.status_index = slot;
        end
        PH_READ: begin
          res.cmd_kind      = CMD_READ;
          res.cmd_address   = cfg.barometer_address >> 1;
          res.cmd_length    = 3'd4;
          res.status_kind   = STAT_SENSOR;
          res.status_ok     = item.xfer_ok;
          res.status_index  = slot;
          res.reading_valid = 1'b1;
          res.pressure      = press_full[8:0];
          res.temperature   = {item.read_byte_two, item.read_byte_three[7:6]};
        end
        PH_DIS_SENSOR: begin
          res.cmd_kind     = CMD_READ;
          res.cmd_address  = saddr >> 1;
          res.cmd_length   = 3'd1;
          res.status_kind  = STAT_FINGER;
          res.status_ok    = last_sensor | item.xfer_ok;
          res.status_index = finger;
        end
        default: res = '0;
      endcase
    end
  end

endmodule

// File: rtl/tactile_sensor_scan_sequencer_core.sv
// Top level of the tactile sensor scan sequencer: input/output registers and port state.
//
//  channel  | dir | handshake           | payload
//  s_*      | in  | s_tvalid/s_tready   | s_tdata: poll tick for one port
//  m_*      | out | m_tvalid/m_tready   | m_tdata: command, status flag, reading
//  wr_*     | in  | wr_en               | wr_index, wr_data: config write
//
// One beat in, one beat out; a tick passes through the input register and then the
// output register, and a new tick is taken every cycle unless the output stalls. Port
// state lives in a 4-entry register array read by the tick in the input register and
// written when that tick advances, so back-to-back ticks on one port see each other's
// updates. rst clears phases, counters and start times and empties both registers. A
// stalled output holds the input register; s_tready drops only when both are full.
module tactile_sensor_scan_sequencer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // port[1:0], start_scan[2], now_us[34:3], xfer_ok[35], read_byte_zero[43:36],
  // read_byte_two[51:44], read_byte_three[59:52], zero fill[63:60]
  input  logic [tss_pkg::IN_BYTES_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // cmd_kind[1:0], cmd_address[9:2], cmd_length[12:10], cmd_data[28:13],
  // status_kind[30:29], status_ok[31], status_index[37:32], reading_valid[38],
  // pressure[47:39], temperature[57:48], zero fill[63:58]
  output logic [tss_pkg::OUT_BYTES_W-1:0]   m_tdata,
  input  logic                              wr_en,
  input  logic [tss_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]    wr_data
);
  import tss_pkg::*;

  cfg_t        cfg;
  item_t       item;
  logic        item_valid;
  logic        out_free;
  logic        advance;
  port_state_t states [0:PORT_COUNT-1];
  port_state_t cur;
  port_state_t nxt;
  logic        write_state;
  result_t     res;
  result_t     res_q;

  tss_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  assign out_free = !m_tvalid || m_tready;
  assign advance  = item_valid && out_free;
  assign s_tready = !item_valid || out_free;
  assign cur      = states[item.port];

  tss_step u_step (
    .item        (item),
    .cur         (cur),
    .cfg         (cfg),
    .nxt         (nxt),
    .write_state (write_state),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_t'(s_tdata[$bits(item_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        states[i].phase      <= PH_IDLE;
        states[i].counter    <= '0;
        states[i].start_time <= '0;
      end
    end else if (advance && write_state) begin
      states[item.port] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {(OUT_BYTES_W - $bits(result_t))'(0), res_q};

endmodule
